// ----- rtl/dda_lr_pkg.sv -----
`timescale 1ns / 1ps

package dda_lr_pkg;

    localparam int COORD_BITS = 10;
    localparam int REM_BITS   = COORD_BITS + 1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [REM_BITS-1:0]   rem_t;

    // input mode codes
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

endpackage

// ----- rtl/dda_line_rasterizer_top.sv -----
// An accepted advance transaction's pixel is registered and appears at the outputs in the next cycle.
// Throughput: one transaction per cycle unless a held pixel drops in_ready; the segment state
// updates in the accept cycle, bounded by the remainder add and compare against the span.
// A load transaction produces no pixel; an advance with no segment active produces none.
// Reset (rst_n low, asynchronous) clears the segment state and the output valid.
`timescale 1ns / 1ps

module dda_line_rasterizer_top
    import dda_lr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,

    input  logic   in_valid,
    output logic   in_ready,
    input  logic   mode,
    input  coord_t x_start,
    input  coord_t y_start,
    input  coord_t x_end,
    input  coord_t y_end,

    output logic   out_valid,
    input  logic   out_ready,
    output coord_t pixel_x,
    output coord_t pixel_y,
    output logic   last_pixel
);

    logic   active_reg,         active_next;
    logic   x_is_major_reg,     x_is_major_next;
    coord_t major_pos_reg,      major_pos_next;
    coord_t minor_pos_reg,      minor_pos_next;
    logic   major_negative_reg, major_negative_next;
    logic   minor_negative_reg, minor_negative_next;
    coord_t minor_delta_reg,    minor_delta_next;
    coord_t span_reg,           span_next;
    coord_t steps_left_reg,     steps_left_next;
    rem_t   remainder_reg,      remainder_next;

    logic   out_valid_reg,      out_valid_next;
    coord_t pixel_x_reg,        pixel_x_next;
    coord_t pixel_y_reg,        pixel_y_next;
    logic   last_pixel_reg,     last_pixel_next;

    logic   accept;
    logic   emit;
    logic   xneg;
    logic   yneg;
    coord_t ax;
    coord_t ay;
    coord_t minor_out;
    rem_t   rem_sum;
    logic   minor_step;

    assign in_ready   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign emit       = accept && (mode == MODE_ADVANCE) && active_reg;

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign last_pixel = last_pixel_reg;

    // endpoint differences for a load
    always_comb
    begin
        xneg = x_end < x_start;
        yneg = y_end < y_start;
        ax   = xneg ? (x_start - x_end) : (x_end - x_start);
        ay   = yneg ? (y_start - y_end) : (y_end - y_start);
    end

    // remainder accumulator and emitted minor coordinate
    always_comb
    begin
        rem_sum    = remainder_reg + {1'b0, minor_delta_reg};
        minor_step = rem_sum >= {1'b0, span_reg};
        minor_out  = minor_pos_reg;
        if (minor_negative_reg && (remainder_reg != '0))
        begin
            minor_out = minor_pos_reg - coord_t'(1);
        end
    end

    always_comb
    begin
        active_next         = active_reg;
        x_is_major_next     = x_is_major_reg;
        major_pos_next      = major_pos_reg;
        minor_pos_next      = minor_pos_reg;
        major_negative_next = major_negative_reg;
        minor_negative_next = minor_negative_reg;
        minor_delta_next    = minor_delta_reg;
        span_next           = span_reg;
        steps_left_next     = steps_left_reg;
        remainder_next      = remainder_reg;

        if (accept && (mode == MODE_LOAD))
        begin
            x_is_major_next = ax > ay;
            if (ax > ay)
            begin
                major_pos_next      = x_start;
                minor_pos_next      = y_start;
                major_negative_next = xneg;
                minor_negative_next = yneg;
                span_next           = ax;
                minor_delta_next    = ay;
                active_next         = ax != '0;
                steps_left_next     = ax;
            end
            else
            begin
                major_pos_next      = y_start;
                minor_pos_next      = x_start;
                major_negative_next = yneg;
                minor_negative_next = xneg;
                span_next           = ay;
                minor_delta_next    = ax;
                active_next         = ay != '0;
                steps_left_next     = ay;
            end
            remainder_next = '0;
        end
        else if (emit)
        begin
            major_pos_next = major_negative_reg ? (major_pos_reg - coord_t'(1))
                                                : (major_pos_reg + coord_t'(1));
            if (minor_step)
            begin
                remainder_next = rem_sum - {1'b0, span_reg};
                minor_pos_next = minor_negative_reg ? (minor_pos_reg - coord_t'(1))
                                                    : (minor_pos_reg + coord_t'(1));
            end
            else
            begin
                remainder_next = rem_sum;
            end
            steps_left_next = steps_left_reg - coord_t'(1);
            if (steps_left_reg == coord_t'(1))
            begin
                active_next = 1'b0;
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        pixel_x_next    = pixel_x_reg;
        pixel_y_next    = pixel_y_reg;
        last_pixel_next = last_pixel_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            pixel_x_next    = x_is_major_reg ? major_pos_reg : minor_out;
            pixel_y_next    = x_is_major_reg ? minor_out : major_pos_reg;
            last_pixel_next = steps_left_reg == coord_t'(1);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg         <= 1'b0;
            x_is_major_reg     <= 1'b0;
            major_pos_reg      <= '0;
            minor_pos_reg      <= '0;
            major_negative_reg <= 1'b0;
            minor_negative_reg <= 1'b0;
            minor_delta_reg    <= '0;
            span_reg           <= '0;
            steps_left_reg     <= '0;
            remainder_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            active_reg         <= active_next;
            x_is_major_reg     <= x_is_major_next;
            major_pos_reg      <= major_pos_next;
            minor_pos_reg      <= minor_pos_next;
            major_negative_reg <= major_negative_next;
            minor_negative_reg <= minor_negative_next;
            minor_delta_reg    <= minor_delta_next;
            span_reg           <= span_next;
            steps_left_reg     <= steps_left_next;
            remainder_reg      <= remainder_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg    <= pixel_x_next;
        pixel_y_reg    <= pixel_y_next;
        last_pixel_reg <= last_pixel_next;
    end

`ifndef SYNTHESIS
    a_active_span: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (span_reg != '0))
        else $error("active segment with zero span");

    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (remainder_reg < {1'b0, span_reg}))
        else $error("remainder not below span");

    a_steps_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ((steps_left_reg != '0) && (steps_left_reg <= span_reg)))
        else $error("steps left out of range while active");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (mode == MODE_ADVANCE) && active_reg) |=> out_valid)
        else $error("advance transaction produced no pixel");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (steps_left_reg == coord_t'(1))) |=> !active_reg)
        else $error("segment still active after last pixel");
`endif

endmodule

// ----- tb/dda_line_checker.sv -----
`timescale 1ns / 1ps

module dda_line_checker
    import dda_lr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,

    input  logic   in_valid,
    input  logic   in_ready,
    input  logic   mode,
    input  coord_t x_start,
    input  coord_t y_start,
    input  coord_t x_end,
    input  coord_t y_end,

    input  logic   out_valid,
    input  logic   out_ready,
    input  coord_t pixel_x,
    input  coord_t pixel_y,
    input  logic   last_pixel,

    output int     fail_count,
    output int     pending
);

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    pixel_t pixel_queue[$];
    int     mismatches;

    // shadow of the segment walker
    logic   seg_active;
    logic   x_major;
    logic   major_down;
    logic   minor_down;
    coord_t major_pos;
    coord_t minor_pos;
    coord_t minor_delta;
    coord_t span;
    coord_t steps_left;
    rem_t   rem;

    task automatic clear_segment();
        seg_active  = 1'b0;
        x_major     = 1'b0;
        major_down  = 1'b0;
        minor_down  = 1'b0;
        major_pos   = '0;
        minor_pos   = '0;
        minor_delta = '0;
        span        = '0;
        steps_left  = '0;
        rem         = '0;
    endtask

    task automatic load_segment(input coord_t xs, input coord_t ys,
                                input coord_t xe, input coord_t ye);
        coord_t dx;
        coord_t dy;
        logic   x_down;
        logic   y_down;
        x_down = xe < xs;
        y_down = ye < ys;
        dx = x_down ? coord_t'(xs - xe) : coord_t'(xe - xs);
        dy = y_down ? coord_t'(ys - ye) : coord_t'(ye - ys);
        // ties go to y as the major axis
        x_major = dx > dy;
        if (x_major)
        begin
            major_pos   = xs;
            minor_pos   = ys;
            major_down  = x_down;
            minor_down  = y_down;
            span        = dx;
            minor_delta = dy;
        end
        else
        begin
            major_pos   = ys;
            minor_pos   = xs;
            major_down  = y_down;
            minor_down  = x_down;
            span        = dy;
            minor_delta = dx;
        end
        steps_left = span;
        rem        = '0;
        seg_active = span != '0;
    endtask

    task automatic walk_pixel();
        coord_t minor_out;
        pixel_t pix;
        rem_t   acc;
        if (!seg_active)
            return;
        // floor of a negative fraction rounds one further down
        minor_out = (minor_down && rem != '0) ? coord_t'(minor_pos - 1'b1) : minor_pos;
        pix.x    = x_major ? major_pos : minor_out;
        pix.y    = x_major ? minor_out : major_pos;
        pix.last = steps_left == coord_t'(1);
        pixel_queue.push_back(pix);

        major_pos = major_down ? coord_t'(major_pos - 1'b1) : coord_t'(major_pos + 1'b1);
        acc = rem + rem_t'(minor_delta);
        if (acc >= rem_t'(span))
        begin
            acc       = acc - rem_t'(span);
            minor_pos = minor_down ? coord_t'(minor_pos - 1'b1)
                                   : coord_t'(minor_pos + 1'b1);
        end
        rem        = acc;
        steps_left = steps_left - 1'b1;
        if (steps_left == '0)
            seg_active = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            clear_segment();
            pixel_queue.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pixel_queue.size() == 0)
                begin
                    $display("%0t: unexpected pixel x=%0d y=%0d last=%0b",
                             $time, pixel_x, pixel_y, last_pixel);
                    mismatches++;
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    if (pixel_x !== want.x)
                    begin
                        $display("%0t: pixel_x expected %0d got %0d", $time, want.x, pixel_x);
                        mismatches++;
                    end
                    if (pixel_y !== want.y)
                    begin
                        $display("%0t: pixel_y expected %0d got %0d", $time, want.y, pixel_y);
                        mismatches++;
                    end
                    if (last_pixel !== want.last)
                    begin
                        $display("%0t: last_pixel expected %0b got %0b",
                                 $time, want.last, last_pixel);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (mode == MODE_LOAD)
                    load_segment(x_start, y_start, x_end, y_end);
                else
                    walk_pixel();
            end
            fail_count <= mismatches;
            pending    <= pixel_queue.size();
        end
    end

endmodule

// ----- tb/tb_dda_line_rasterizer_top.sv -----
`timescale 1ns / 1ps

module tb_dda_line_rasterizer_top;
    import dda_lr_pkg::*;

    localparam int ITEM_TARGET = 1900;
    localparam int IDLE_LIMIT  = 500;
    localparam int DRAIN_TAIL  = 8;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    logic   mode;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    logic   out_valid;
    logic   out_ready;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;

    int     fail_count;
    int     pending;
    int     items_done;
    int     seg_left;
    bit     quiet;

    dda_line_rasterizer_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    dda_line_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    // random endpoint within reach of c, clamped to the coordinate range
    function automatic coord_t near(input coord_t c, input int reach);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * reach)) - reach;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return coord_t'(v);
    endfunction

    task automatic send_item(input logic m, input coord_t xs, input coord_t ys,
                             input coord_t xe, input coord_t ye);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        x_start  <= xs;
        y_start  <= ys;
        x_end    <= xe;
        y_end    <= ye;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic load_line(input coord_t xs, input coord_t ys,
                             input coord_t xe, input coord_t ye);
        int dx;
        int dy;
        send_item(MODE_LOAD, xs, ys, xe, ye);
        dx = (xe > xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
        dy = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
        seg_left = (dx > dy) ? dx : dy;
        items_done++;
    endtask

    // advance transactions carry junk coordinates; only live ones count
    task automatic advance(input int n);
        repeat (n)
        begin
            send_item(MODE_ADVANCE,
                      coord_t'($urandom_range(0, 1023)), coord_t'($urandom_range(0, 1023)),
                      coord_t'($urandom_range(0, 1023)), coord_t'($urandom_range(0, 1023)));
            if (seg_left > 0)
            begin
                seg_left--;
                items_done++;
            end
        end
    endtask

    // output side: hold out_ready low for a random stall before each pixel is taken
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int     kind;
        int     n;
        coord_t xs;
        coord_t ys;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_LOAD;
        x_start    = '0;
        y_start    = '0;
        x_end      = '0;
        y_end      = '0;
        items_done = 0;
        seg_left   = 0;
        quiet      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing loaded yet, then a zero-length segment
        advance(1);
        load_line(7, 7, 7, 7);
        advance(1);
        // full-range diagonals, each cut short by the next load
        load_line(0, 1023, 1023, 0);
        advance(3);
        load_line(1023, 0, 0, 1023);
        advance(2);
        load_line(1023, 1023, 0, 0);
        advance(2);
        // x major, minor rising
        load_line(2, 3, 6, 5);
        advance(4);
        // y major, minor falling, run past the end
        load_line(5, 0, 2, 5);
        advance(6);

        while (items_done < ITEM_TARGET)
        begin
            quiet = $urandom_range(0, 5) == 0;
            kind  = $urandom_range(0, 9);
            xs    = coord_t'($urandom_range(0, 1023));
            ys    = coord_t'($urandom_range(0, 1023));
            if (kind < 7)
            begin
                load_line(xs, ys, near(xs, 24), near(ys, 24));
                n = seg_left + $urandom_range(0, 1);
                advance(n);
            end
            else if (kind < 9)
            begin
                load_line(xs, ys, coord_t'($urandom_range(0, 1023)),
                          coord_t'($urandom_range(0, 1023)));
                n = ($urandom_range(0, 19) == 0) ? seg_left : $urandom_range(0, 40);
                advance(n);
            end
            else
            begin
                load_line(xs, ys, xs, ys);
                advance($urandom_range(0, 2));
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
